>>> rtl/ril_pkg.sv
// ----------------------------------------------------------------------------
// ril_pkg
// shared types, constants and helpers of the recent items list
// ----------------------------------------------------------------------------
`default_nettype none

package ril_pkg;

    // list geometry
    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // smallest capacity the list honors
    localparam int MIN_CAPACITY = 5;

    // configuration port
    localparam int CAP_W     = 5;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_EVICT = 1'd1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // request modes
    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_POP    = 2'd2,
        MODE_EXISTS = 2'd3
    } t_mode;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_POP,
        ST_APPLY
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic walk;
        logic pop_rd;
        logic apply;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_free;
    } t_sts;

    // ring index plus offset, offset at most DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // capacity register limited to the supported range
    function automatic logic [CNT_W-1:0] clamp_capacity(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] res;
        if (cap < CAP_W'(MIN_CAPACITY)) begin
            res = CNT_W'(MIN_CAPACITY);
        end else if (int'(cap) > DEPTH) begin
            res = CNT_W'(DEPTH);
        end else begin
            res = CNT_W'(cap);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ril_req_if.sv
// ----------------------------------------------------------------------------
// ril_req_if
// request channel of the recent items list
// ----------------------------------------------------------------------------
`default_nettype none

interface ril_req_if;
    logic                             valid;
    logic                             ready;
    ril_pkg::t_mode                   mode;
    logic [ril_pkg::KEY_BITS-1:0]     key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

`default_nettype wire

>>> rtl/ril_rsp_if.sv
// ----------------------------------------------------------------------------
// ril_rsp_if
// response channel of the recent items list
// ----------------------------------------------------------------------------
`default_nettype none

interface ril_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             ok;
    logic [ril_pkg::KEY_BITS-1:0]     key_out;
    logic [ril_pkg::CNT_W-1:0]        removed_count;
    logic [ril_pkg::CNT_W-1:0]        entry_count;

    modport source (output valid, output ok, output key_out, output removed_count,
                    output entry_count, input ready);
    modport sink   (input valid, input ok, input key_out, input removed_count,
                    input entry_count, output ready);
endinterface

`default_nettype wire

>>> rtl/ril_ctrl.sv
// ----------------------------------------------------------------------------
// ril_ctrl
// sequencer: accept, walk or pop read, apply and respond
// ----------------------------------------------------------------------------
`default_nettype none

module ril_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    input  ril_pkg::t_mode      i_req_mode,
    output logic                o_req_ready,
    input  ril_pkg::t_sts       i_sts,
    output ril_pkg::t_cmd       o_cmd
);

    ril_pkg::t_state r_state;
    ril_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ril_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ril_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req_mode == ril_pkg::MODE_POP) ? ril_pkg::ST_POP
                                                                 : ril_pkg::ST_WALK;
                end
            end
            ril_pkg::ST_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = ril_pkg::ST_APPLY;
                end
            end
            ril_pkg::ST_POP: begin
                n_state = ril_pkg::ST_APPLY;
            end
            ril_pkg::ST_APPLY: begin
                if (i_sts.out_free) begin
                    n_state = ril_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ril_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_req_ready  = 1'b0;
        o_cmd        = '0;
        case (r_state)
            ril_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            ril_pkg::ST_WALK: begin
                o_cmd.walk = 1'b1;
            end
            ril_pkg::ST_POP: begin
                o_cmd.pop_rd = 1'b1;
            end
            ril_pkg::ST_APPLY: begin
                o_cmd.apply = i_sts.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/ril_dp.sv
// ----------------------------------------------------------------------------
// ril_dp
// entry ring, compaction walk, list update and response register
// ----------------------------------------------------------------------------
`default_nettype none

module ril_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ril_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ril_pkg::CFG_W-1:0]         i_cfg_data,
    input  ril_pkg::t_mode                         i_mode,
    input  wire logic [ril_pkg::KEY_BITS-1:0]      i_key,
    input  ril_pkg::t_cmd                          i_cmd,
    output ril_pkg::t_sts                          o_sts,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic                                   o_ok,
    output logic [ril_pkg::KEY_BITS-1:0]           o_key_out,
    output logic [ril_pkg::CNT_W-1:0]              o_removed_count,
    output logic [ril_pkg::CNT_W-1:0]              o_entry_count
);

    localparam int IW = ril_pkg::IDX_W;
    localparam int CW = ril_pkg::CNT_W;
    localparam int KW = ril_pkg::KEY_BITS;

    // entry ring, oldest at r_head
    logic [KW-1:0] mem [ril_pkg::DEPTH];
    logic [KW-1:0] r_rdata;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [KW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;

    // config
    logic [ril_pkg::CAP_W-1:0] r_capacity;
    logic                      r_auto_evict;

    // list state and walk
    logic [IW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_fill, n_fill;
    logic [CW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_wr, n_wr;
    logic           r_rd_vld, n_rd_vld;
    logic [KW-1:0]  r_key, n_key;
    ril_pkg::t_mode r_mode, n_mode;

    // response
    logic           r_out_valid, n_out_valid;
    logic           r_ok, n_ok;
    logic [KW-1:0]  r_key_out, n_key_out;
    logic [CW-1:0]  r_removed, n_removed;
    logic [CW-1:0]  r_count, n_count;

    logic [CW-1:0]  cap;
    logic           full;
    logic [CW-1:0]  evict;
    logic           issue;
    logic           compacts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= ril_pkg::CAPACITY_RESET;
            r_auto_evict <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ril_pkg::REG_CAPACITY:   r_capacity   <= i_cfg_data[ril_pkg::CAP_W-1:0];
                ril_pkg::REG_AUTO_EVICT: r_auto_evict <= i_cfg_data[0];
                default:                 r_auto_evict <= r_auto_evict;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_comb begin
        cap      = ril_pkg::clamp_capacity(r_capacity);
        full     = (r_wr >= cap);
        evict    = full ? (r_wr - cap + CW'(1)) : '0;
        issue    = (r_rd != r_fill);
        compacts = (r_mode == ril_pkg::MODE_APPEND) || (r_mode == ril_pkg::MODE_REMOVE);

        n_head      = r_head;
        n_fill      = r_fill;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_rd_vld    = r_rd_vld;
        n_key       = r_key;
        n_mode      = r_mode;
        n_out_valid = r_out_valid;
        n_ok        = r_ok;
        n_key_out   = r_key_out;
        n_removed   = r_removed;
        n_count     = r_count;

        mem_we    = 1'b0;
        mem_waddr = ril_pkg::wrap_add(r_head, r_wr);
        mem_wdata = r_key;
        mem_re    = 1'b0;
        mem_raddr = ril_pkg::wrap_add(r_head, r_rd);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.load) begin
            n_key    = i_key;
            n_mode   = i_mode;
            n_rd     = '0;
            n_wr     = '0;
            n_rd_vld = 1'b0;
        end

        // read one entry per cycle, keep the ones that differ from the key
        if (i_cmd.walk) begin
            mem_re    = issue;
            mem_wdata = r_rdata;
            n_rd      = r_rd + CW'(issue);
            n_rd_vld  = issue;
            if (r_rd_vld && (r_rdata != r_key)) begin
                n_wr   = r_wr + CW'(1);
                mem_we = compacts;
            end
        end

        if (i_cmd.pop_rd) begin
            mem_re    = 1'b1;
            mem_raddr = r_head;
        end

        if (i_cmd.apply) begin
            n_out_valid = 1'b1;
            n_ok        = 1'b0;
            n_key_out   = '0;
            n_removed   = '0;
            case (r_mode)
                ril_pkg::MODE_APPEND: begin
                    n_fill = r_wr;
                    if (!full || r_auto_evict) begin
                        // new key goes behind the survivors, oldest ones drop off
                        mem_we    = 1'b1;
                        n_head    = ril_pkg::wrap_add(r_head, evict);
                        n_fill    = r_wr - evict + CW'(1);
                        n_ok      = 1'b1;
                        n_key_out = r_key;
                    end
                end
                ril_pkg::MODE_REMOVE: begin
                    n_fill    = r_wr;
                    n_removed = r_fill - r_wr;
                end
                ril_pkg::MODE_POP: begin
                    if (r_fill != '0) begin
                        n_ok      = 1'b1;
                        n_key_out = r_rdata;
                        n_head    = ril_pkg::wrap_add(r_head, CW'(1));
                        n_fill    = r_fill - CW'(1);
                    end
                end
                ril_pkg::MODE_EXISTS: begin
                    n_ok = (r_wr != r_fill);
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
            n_count = n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd      <= n_rd;
        r_wr      <= n_wr;
        r_key     <= n_key;
        r_mode    <= n_mode;
        r_ok      <= n_ok;
        r_key_out <= n_key_out;
        r_removed <= n_removed;
        r_count   <= n_count;
    end

    assign o_sts.walk_done = (r_rd == r_fill) && !r_rd_vld;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_ok;
    assign o_key_out       = r_key_out;
    assign o_removed_count = r_removed;
    assign o_entry_count   = r_count;

endmodule

`default_nettype wire

>>> rtl/recent_items_list.sv
// ----------------------------------------------------------------------------
// recent_items_list
// age-ordered list of recent keys with append, remove, pop and lookup
// ----------------------------------------------------------------------------
// The block holds up to capacity keys (5 to 16, register 0) oldest first in a
// 16-entry ring. Each request gives exactly one response. Append, remove and
// exists walk the held entries through the ring's single read port, one entry
// per cycle; append and remove compact out keys equal to the request key. The
// response is loaded after the walk ends, and the next request is taken when
// the sequencer is back in idle. Pop reads the oldest slot, loads its response
// and then returns to idle for the next request. The final step stalls while
// the previous response still waits on o_rsp.ready.
// A full list on append evicts its oldest entries (auto_evict, register 1,
// set) or rejects the key. The response sits in an output register, so a new
// request is taken while the previous response still waits on o_rsp.ready.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module recent_items_list (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [ril_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ril_pkg::CFG_W-1:0]         i_cfg_data,
    // request and response channels
    ril_req_if.sink                                i_req,
    ril_rsp_if.source                              o_rsp
);

    ril_pkg::t_cmd cmd;
    ril_pkg::t_sts sts;
    logic          req_ready;

    // sequencer: idle, walk or pop read, then apply once the response slot is free
    ril_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_mode  (i_req.mode),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // ring storage, walk counters, list update and response register
    ril_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_req.mode),
        .i_key           (i_req.key),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_ok            (o_rsp.ok),
        .o_key_out       (o_rsp.key_out),
        .o_removed_count (o_rsp.removed_count),
        .o_entry_count   (o_rsp.entry_count)
    );

    // request taken only in idle
    assign i_req.ready = req_ready;

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the recent items list
// ----------------------------------------------------------------------------
// A short directed run covers the empty list, the extreme keys, every mode,
// capacity saturation and rejection on a full list. Random segments follow,
// each under its own capacity and eviction setting. A mirror of the list
// inside a scoreboard class predicts each response as its request is
// accepted, and every accepted response is compared field by field with the
// oldest prediction. Sender and receiver stall at random in two of the three
// idling phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ril_pkg::*;

    localparam int NUM_SEGMENTS  = 6;
    localparam int SEGMENT_ITEMS = 215;
    localparam int KEY_POOL_SIZE = 20;
    localparam int SETTLE_CYCLES = 24;        // beyond the worst request latency
    localparam int CYCLE_LIMIT   = 400000;

    // capacity and eviction setting per random segment; a full list at 16 is
    // followed by a lower capacity so the list sits above its new limit
    localparam logic [CFG_W-1:0] SEG_CAPACITY [NUM_SEGMENTS] =
        '{5'd16, 5'd5, 5'd31, 5'd4, 5'd0, 5'd11};
    localparam logic SEG_AUTO_EVICT [NUM_SEGMENTS] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    // one response of the list
    typedef struct packed {
        logic                ok;
        logic [KEY_BITS-1:0] key_out;
        logic [CNT_W-1:0]    removed_count;
        logic [CNT_W-1:0]    entry_count;
    } t_list_response;

    // mirror of the list plus the responses still owed by the block
    class recent_list_tracker;
        logic [KEY_BITS-1:0] held_keys[$];        // oldest first
        logic [CAP_W-1:0]    capacity;
        logic                auto_evict;
        t_list_response      pending_responses[$];
        int unsigned         mismatches;

        function new();
            capacity   = CAPACITY_RESET;
            auto_evict = 1'b1;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_CAPACITY) begin
                capacity = data[CAP_W-1:0];
            end else begin
                auto_evict = data[0];
            end
        endfunction

        // delete every held copy of a key, return how many went
        function int unsigned drop_key(logic [KEY_BITS-1:0] key);
            int unsigned gone = 0;
            for (int i = held_keys.size() - 1; i >= 0; i--) begin
                if (held_keys[i] == key) begin
                    held_keys.delete(i);
                    gone++;
                end
            end
            return gone;
        endfunction

        // apply an accepted request to the mirror and queue its response
        function void note_request(t_mode mode, logic [KEY_BITS-1:0] key);
            t_list_response rsp;
            int             limit;
            rsp   = '0;
            limit = int'(capacity);
            if (limit < MIN_CAPACITY) begin
                limit = MIN_CAPACITY;
            end
            if (limit > DEPTH) begin
                limit = DEPTH;
            end
            case (mode)
                MODE_APPEND: begin
                    void'(drop_key(key));
                    // full list either makes room from the old end or rejects
                    if (held_keys.size() < limit || auto_evict) begin
                        while (held_keys.size() >= limit) begin
                            void'(held_keys.pop_front());
                        end
                        held_keys.push_back(key);
                        rsp.ok      = 1'b1;
                        rsp.key_out = key;
                    end
                end
                MODE_REMOVE: begin
                    rsp.removed_count = CNT_W'(drop_key(key));
                end
                MODE_POP: begin
                    if (held_keys.size() > 0) begin
                        rsp.key_out = held_keys.pop_front();
                        rsp.ok      = 1'b1;
                    end
                end
                MODE_EXISTS: begin
                    foreach (held_keys[i]) begin
                        if (held_keys[i] == key) begin
                            rsp.ok = 1'b1;
                        end
                    end
                end
            endcase
            rsp.entry_count = CNT_W'(held_keys.size());
            pending_responses.push_back(rsp);
        endfunction

        function void compare_field(string name, logic [KEY_BITS-1:0] want,
                                    logic [KEY_BITS-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(t_list_response got);
            t_list_response want;
            if (pending_responses.size() == 0) begin
                $display("%0t: response with none outstanding, expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = pending_responses.pop_front();
            compare_field("ok", KEY_BITS'(want.ok), KEY_BITS'(got.ok));
            compare_field("key_out", want.key_out, got.key_out);
            compare_field("removed_count", KEY_BITS'(want.removed_count),
                          KEY_BITS'(got.removed_count));
            compare_field("entry_count", KEY_BITS'(want.entry_count),
                          KEY_BITS'(got.entry_count));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    ril_req_if req_ch ();
    ril_rsp_if rsp_ch ();

    recent_items_list dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    recent_list_tracker  history;
    int unsigned         send_idle_pct;
    int unsigned         recv_idle_pct;
    int unsigned         cycle_count;
    logic [KEY_BITS-1:0] key_pool [KEY_POOL_SIZE];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: ready drops at random according to the current phase
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // every accepted response is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            history.check_response({rsp_ch.ok, rsp_ch.key_out, rsp_ch.removed_count,
                                    rsp_ch.entry_count});
        end
    end

    // watchdog against a hung handshake
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb failed");
        $finish;
    end

    // present one request, optionally after idle cycles, and wait for acceptance;
    // valid is left high so back-to-back requests need no extra assignment
    task automatic send_request(t_mode mode, logic [KEY_BITS-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.key   <= key;
        do @(posedge i_clk); while (!req_ch.ready);
        history.note_request(mode, key);
    endtask

    // stop sending until every owed response has arrived, then settle
    task automatic hold_until_drained(int unsigned settle);
        req_ch.valid <= 1'b0;
        while (history.pending_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // both registers, written back to back while the block is idle
    task automatic write_settings(logic [CFG_W-1:0] capacity, logic auto_evict);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_CAPACITY;
        cfg_data <= capacity;
        @(posedge i_clk);
        history.set_register(REG_CAPACITY, capacity);
        cfg_idx  <= REG_AUTO_EVICT;
        cfg_data <= CFG_W'(auto_evict);
        @(posedge i_clk);
        history.set_register(REG_AUTO_EVICT, CFG_W'(auto_evict));
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly keys from a small pool so that hits, duplicates and full lists occur
    function automatic logic [KEY_BITS-1:0] pick_key();
        if ($urandom_range(99) < 85) begin
            return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    // appends dominate so the list fills up and stays full
    function automatic t_mode pick_mode();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45) begin
            return MODE_APPEND;
        end else if (r < 60) begin
            return MODE_REMOVE;
        end else if (r < 75) begin
            return MODE_POP;
        end
        return MODE_EXISTS;
    endfunction

    initial begin
        history = new();

        // known values on every input from the start
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= REG_CAPACITY;
        cfg_data     <= '0;
        req_ch.valid <= 1'b0;
        req_ch.mode  <= MODE_APPEND;
        req_ch.key   <= '0;

        // phase one idling: sender lightly, receiver heavily
        send_idle_pct = 16;
        recv_idle_pct = 87;

        // the pool always holds both extreme keys
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: pop finds nothing, lookup misses, remove deletes nothing
        send_request(MODE_POP, '0);
        send_request(MODE_EXISTS, '0);
        send_request(MODE_REMOVE, '0);
        // extreme keys; re-appending a held key moves it to the newest slot
        send_request(MODE_APPEND, '0);
        send_request(MODE_APPEND, '1);
        send_request(MODE_APPEND, '0);
        send_request(MODE_EXISTS, '1);
        send_request(MODE_EXISTS, 32'h0000_0001);
        send_request(MODE_REMOVE, '1);
        send_request(MODE_POP, '0);

        // capacity below the minimum acts as five; a full list rejects a new key
        // but still takes one it already holds
        hold_until_drained(SETTLE_CYCLES);
        write_settings(5'd0, 1'b0);
        for (int i = 0; i < 6; i++) begin
            send_request(MODE_APPEND, 32'h8000_0000 + 32'(i));
        end
        send_request(MODE_APPEND, 32'h8000_0002);
        send_request(MODE_POP, '0);

        // eviction on a full list of five
        hold_until_drained(SETTLE_CYCLES);
        write_settings(5'd3, 1'b1);
        send_request(MODE_APPEND, 32'h7fff_ffff);
        send_request(MODE_APPEND, 32'h1234_5678);

        // random segments, each under its own setting; idling phases change
        // every two segments and the last phase runs without stalls
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            hold_until_drained(SETTLE_CYCLES);
            write_settings(SEG_CAPACITY[seg], SEG_AUTO_EVICT[seg]);
            case (seg / 2)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 87;
                end
                1: begin
                    send_idle_pct = 87;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                // occasionally let the block run completely dry
                if ($urandom_range(99) < 2) begin
                    hold_until_drained(0);
                end
                send_request(pick_mode(), pick_key());
            end
        end

        hold_until_drained(SETTLE_CYCLES);
        if (history.mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/ril_pkg.sv
rtl/ril_req_if.sv
rtl/ril_rsp_if.sv
rtl/ril_ctrl.sv
rtl/ril_dp.sv
rtl/recent_items_list.sv
bench/tb.sv
